>>> rtl/msfr_pkg.sv
`timescale 1ns / 1ps
// shared constants and types for the marker sync frame receiver
// no dependencies

package msfr_pkg;

    localparam int BYTE_W   = 8;
    localparam int POS_W    = 7;
    localparam int TALLY_W  = 16;
    localparam int WORD_W   = 32;
    localparam int AXIS_MAX = 5;

    localparam logic [BYTE_W-1:0]  MARK_BYTE    = 8'h2A;
    localparam logic [POS_W-1:0]   TRAILER_SKIP = 7'd3;
    localparam logic [TALLY_W-1:0] TALLY_MAX    = 16'hFFFF;

    // what the sync controller reports for the word it just processed
    typedef struct packed {
        logic               done;
        logic               good;
        logic               first;
        logic [TALLY_W-1:0] tally;
    } frame_evt_t;

endpackage

>>> rtl/msfr_hist.sv
`timescale 1ns / 1ps
// byte history shift line holding the most recent frame bytes
// depends on msfr_pkg

module msfr_hist
    import msfr_pkg::*;
#(
    parameter int DEPTH = 23
)
(
    input  logic                         clk,
    input  logic                         shift_en,
    input  logic [BYTE_W-1:0]            din,
    output logic [DEPTH-1:0][BYTE_W-1:0] taps
);

    logic [DEPTH-1:0][BYTE_W-1:0] hist_reg;
    logic [DEPTH-1:0][BYTE_W-1:0] hist_next;

    // tap 0 is the newest byte
    always_comb
    begin
        hist_next = hist_reg;
        if (shift_en)
        begin
            hist_next[0] = din;
            for (int i = 1; i < DEPTH; i++)
            begin
                hist_next[i] = hist_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        hist_reg <= hist_next;
    end

    assign taps = hist_reg;

endmodule

>>> rtl/msfr_sync.sv
`timescale 1ns / 1ps
// lock state machine: marker search, confirm, trailer skip and frame receive
// depends on msfr_pkg

module msfr_sync
    import msfr_pkg::*;
#(
    parameter int FRAME_LENGTH = 24
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [BYTE_W-1:0] rx_byte,
    input  logic [BYTE_W-1:0] marker_byte,
    output logic              store_en,
    output frame_evt_t        evt
);

    typedef enum logic [1:0] {
        PH_UNSYNC,
        PH_CONFIRM,
        PH_ROLLOUT,
        PH_RECEIVE
    } phase_t;

    localparam logic [POS_W-1:0] FL = POS_W'(FRAME_LENGTH);

    phase_t             phase_reg, phase_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [TALLY_W-1:0] tally_reg, tally_next;
    logic               seen_reg, seen_next;
    logic [POS_W-1:0]   pos_inc;

    assign pos_inc  = pos_reg + POS_W'(1);
    assign store_en = (phase_reg == PH_RECEIVE) && (pos_reg < FL);

    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        tally_next = tally_reg;
        seen_next  = seen_reg;
        evt.done   = 1'b0;
        evt.good   = 1'b0;
        evt.first  = 1'b0;
        case (phase_reg)
            PH_UNSYNC:
            begin
                if (rx_byte == MARK_BYTE)
                begin
                    phase_next = PH_CONFIRM;
                    pos_next   = '0;
                end
            end
            PH_CONFIRM:
            begin
                pos_next = pos_inc;
                if (pos_inc == FL && rx_byte == MARK_BYTE)
                begin
                    phase_next = PH_ROLLOUT;
                    pos_next   = '0;
                end
                if (pos_inc > FL)
                begin
                    phase_next = PH_UNSYNC;
                end
            end
            PH_ROLLOUT:
            begin
                pos_next = pos_inc;
                if (pos_inc == TRAILER_SKIP)
                begin
                    phase_next = PH_RECEIVE;
                    pos_next   = '0;
                end
            end
            PH_RECEIVE:
            begin
                // frame is checked once the last byte lands
                if (pos_reg < FL)
                begin
                    pos_next = pos_inc;
                    evt.done = (pos_inc >= FL);
                end
                else
                begin
                    evt.done = 1'b1;
                end
                if (evt.done)
                begin
                    if (marker_byte == MARK_BYTE)
                    begin
                        evt.good  = 1'b1;
                        evt.first = !seen_reg;
                        seen_next = 1'b1;
                        pos_next  = '0;
                    end
                    else
                    begin
                        if (tally_reg != TALLY_MAX)
                        begin
                            tally_next = tally_reg + TALLY_W'(1);
                        end
                        phase_next = PH_UNSYNC;
                    end
                end
            end
            default:
            begin
                phase_next = PH_UNSYNC;
            end
        endcase
        evt.tally = tally_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_UNSYNC;
            pos_reg   <= '0;
            tally_reg <= '0;
            seen_reg  <= 1'b0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            tally_reg <= tally_next;
            seen_reg  <= seen_next;
        end
    end

endmodule

>>> rtl/marker_sync_frame_receiver_top.sv
`timescale 1ns / 1ps
// top level of the marker sync frame receiver: input and result registers
// depends on msfr_pkg, msfr_sync, msfr_hist

// One received byte per word, one word per clock while the output is not
// stalled. A byte is taken into the input register; the lock state machine
// and the byte history shift line then process it and, when a frame
// completes, the result register is loaded. Only a result left waiting at a
// stalled output holds the input side back, and then only once the input
// register is also full.
// FRAME_LENGTH sets the depth of the history shift line (FRAME_LENGTH-1
// bytes); AXIS_COUNT axis words are filled, the rest read as zero.

module marker_sync_frame_receiver_top
    import msfr_pkg::*;
#(
    parameter int FRAME_LENGTH = 24,
    parameter int AXIS_COUNT   = 5
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [BYTE_W-1:0]  rx_byte,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               frame_good,
    output logic               frame_bad,
    output logic [WORD_W-1:0]  axis_word_0,
    output logic [WORD_W-1:0]  axis_word_1,
    output logic [WORD_W-1:0]  axis_word_2,
    output logic [WORD_W-1:0]  axis_word_3,
    output logic [WORD_W-1:0]  axis_word_4,
    output logic [BYTE_W-1:0]  status_bits,
    output logic               first_frame,
    output logic [TALLY_W-1:0] bad_frame_total
);

    localparam int HIST_DEPTH = FRAME_LENGTH - 1;

    logic                 in_valid_reg, in_valid_next;
    logic [BYTE_W-1:0]    in_byte_reg;
    logic                 in_accept;
    logic                 fire;

    logic                 store_en;
    frame_evt_t           evt;
    logic [HIST_DEPTH-1:0][BYTE_W-1:0] taps;

    logic                 out_valid_reg, out_valid_next;
    logic                 good_reg, bad_reg, first_reg;
    logic [BYTE_W-1:0]    status_reg;
    logic [TALLY_W-1:0]   tally_reg;
    logic [AXIS_MAX-1:0][WORD_W-1:0] axis_reg;
    logic [AXIS_MAX-1:0][WORD_W-1:0] axis_next;

    // the processing stage moves only when the result slot is free or leaving
    assign fire      = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && !fire;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (fire)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (fire && evt.done)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    msfr_sync #(
        .FRAME_LENGTH (FRAME_LENGTH)
    ) u_sync (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (fire),
        .rx_byte     (in_byte_reg),
        .marker_byte (taps[2]),
        .store_en    (store_en),
        .evt         (evt)
    );

    msfr_hist #(
        .DEPTH (HIST_DEPTH)
    ) u_hist (
        .clk      (clk),
        .shift_en (fire && store_en),
        .din      (in_byte_reg),
        .taps     (taps)
    );

    // frame byte p sits at tap FRAME_LENGTH-2-p while the last byte is current
    always_comb
    begin
        axis_next = '0;
        for (int k = 0; k < AXIS_MAX; k++)
        begin
            if (k < AXIS_COUNT && evt.good)
            begin
                for (int b = 0; b < 4; b++)
                begin
                    axis_next[k][b*BYTE_W +: BYTE_W] = taps[FRAME_LENGTH - 2 - (4*k + b)];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_byte_reg <= rx_byte;
        end
        if (fire && evt.done)
        begin
            good_reg   <= evt.good;
            bad_reg    <= !evt.good;
            first_reg  <= evt.first;
            tally_reg  <= evt.tally;
            status_reg <= evt.good ? in_byte_reg : '0;
            axis_reg   <= axis_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign frame_good      = good_reg;
    assign frame_bad       = bad_reg;
    assign first_frame     = first_reg;
    assign bad_frame_total = tally_reg;
    assign status_bits     = status_reg;
    assign axis_word_0     = axis_reg[0];
    assign axis_word_1     = axis_reg[1];
    assign axis_word_2     = axis_reg[2];
    assign axis_word_3     = axis_reg[3];
    assign axis_word_4     = axis_reg[4];

endmodule
